// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
// All checks sample on the rising edge of aclk; ASSERT_CLK checks are quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check clocked on aclk, disabled while aresetn is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same check, but it also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== src/skt_pkg.sv =====
// ---------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table: sizes, operation
// and status codes, and the packed layouts of the stream data words.
// ---------------------------------------------------------------------------
package skt_pkg;

    // table sizing
    localparam int CAPACITY  = 64;
    localparam int KEY_BITS  = 32;
    localparam int VAL_BITS  = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int REC_W     = KEY_BITS + VAL_BITS;
    localparam int PRB_W     = 4;

    // fixed field widths on the ports
    localparam int MODE_W    = 2;
    localparam int STAT_W    = 2;
    localparam int POS_W     = 7;
    localparam int LIMIT_W   = 7;
    localparam int PROBE_W   = 3;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 56;

    // operation codes carried in s_tuser
    typedef enum logic [MODE_W-1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_OTHER  = 2'd3
    } skt_op_t;

    // status codes carried in m_tuser
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUPLICATE = 2'd3
    } skt_status_t;

    // input tdata, highest field first
    typedef struct packed {
        logic [31:0] value;
        logic [31:0] key;
    } skt_in_data_t;

    // output tdata, highest field first
    typedef struct packed {
        logic [6:0]         pad;
        logic [PROBE_W-1:0] probes;
        logic [POS_W-1:0]   entry_count;
        logic [31:0]        found_value;
        logic [POS_W-1:0]   position;
    } skt_out_data_t;

endpackage

// ===== src/skt_ram.sv =====
// ---------------------------------------------------------------------------
// skt_ram
// Simple dual-port record memory: one write port, one read port with the
// read data registered.
// ---------------------------------------------------------------------------
module skt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/sorted_key_table.sv =====
// Per input beat: a binary search of P probes (at most 7) locates the key or its
//   insertion point; a find hit or duplicate insert then gives its result, a find or
//   delete miss is not found, a stored insert moves M records (up to 63) up and writes
//   it, a delete hit moves M records down; an insert refused as full skips the search.
// Throughput: one item at a time; s_tready stays low until the result is loaded.
// Reset: synchronous, active low; clears the count, sets the limit to 64.
// ---------------------------------------------------------------------------
// sorted_key_table
// Key/value table kept sorted by ascending key. Each input beat is a find,
// insert or delete; a binary search over the record memory locates the key
// or its insertion point, and inserts and deletes move the upper records.
// ---------------------------------------------------------------------------
module sorted_key_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: table_limit
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [skt_pkg::LIMIT_W-1:0]   cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [skt_pkg::IN_DATA_W-1:0] s_tdata,   // key[31:0], value[63:32]
    input  logic [skt_pkg::MODE_W-1:0]    s_tuser,   // mode[1:0]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [skt_pkg::OUT_DATA_W-1:0] m_tdata,  // position[6:0],
                                                     // found_value[38:7],
                                                     // entry_count[45:39],
                                                     // probes[48:46], zero pad
    output logic [skt_pkg::STAT_W-1:0]    m_tuser    // status[1:0]
);

    import skt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHIFT_UP,
        S_STORE,
        S_SHIFT_DN,
        S_RESULT
    } state_t;

    // sequencer and datapath registers
    state_t               state_reg, state_next;
    skt_op_t              op_reg, op_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [VAL_BITS-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;        // exclusive upper bound
    logic [IDX_W-1:0]     mid_reg, mid_next;
    logic [PRB_W-1:0]     probes_reg, probes_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    skt_status_t          status_reg, status_next;
    logic [VAL_BITS-1:0]  fval_reg, fval_next;
    logic [CNT_W-1:0]     cursor_reg, cursor_next;
    logic                 wb_valid_reg, wb_valid_next;
    logic [IDX_W-1:0]     wb_addr_reg, wb_addr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic                 m_valid_reg, m_valid_next;
    skt_out_data_t        m_data_reg, m_data_next;
    skt_status_t          m_status_reg, m_status_next;

    // memory ports
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [REC_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [REC_W-1:0]     ram_rdata;

    logic                 in_beat;
    logic                 table_full;
    logic [CNT_W:0]       mid_sum;
    logic [KEY_BITS-1:0]  rd_key;
    logic [VAL_BITS-1:0]  rd_value;
    skt_in_data_t         in_data;

    assign in_data   = skt_in_data_t'(s_tdata);
    assign s_tready  = (state_reg == S_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign rd_key    = ram_rdata[REC_W-1:VAL_BITS];
    assign rd_value  = ram_rdata[VAL_BITS-1:0];

    // midpoint of [lo, hi-1]
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W+1)'(1);

    // effective limit is table_limit capped at the capacity
    assign table_full = (32'(count_reg) >= 32'(limit_reg)) ||
                        (32'(count_reg) >= 32'(CAPACITY));

    skt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (REC_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        probes_next   = probes_reg;
        pos_next      = pos_reg;
        status_next   = status_reg;
        fval_next     = fval_reg;
        cursor_next   = cursor_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        count_next    = count_reg;
        limit_next    = limit_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        ram_we        = 1'b0;
        ram_waddr     = wb_addr_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = mid_sum[IDX_W:1];

        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end

        // result beat taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    op_next     = skt_op_t'(s_tuser);
                    key_next    = in_data.key[KEY_BITS-1:0];
                    value_next  = in_data.value;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    probes_next = '0;
                    pos_next    = '0;
                    fval_next   = '0;
                    status_next = ST_OK;
                    if (skt_op_t'(s_tuser) == OP_INSERT && table_full) begin
                        status_next = ST_FULL;
                        state_next  = S_RESULT;
                    end else begin
                        state_next  = S_PROBE;
                    end
                end
            end

            // issue a probe read, or end the search: not found, or the insertion point for an insert
            S_PROBE: begin
                if (lo_reg < hi_reg) begin
                    mid_next    = mid_sum[IDX_W:1];
                    probes_next = probes_reg + PRB_W'(1);
                    state_next  = S_CMP;
                end else begin
                    pos_next = lo_reg;
                    if (op_reg == OP_INSERT) begin
                        cursor_next = count_reg;
                        state_next  = S_SHIFT_UP;
                    end else begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_RESULT;
                    end
                end
            end

            // compare the probed key
            S_CMP: begin
                if (rd_key == key_reg) begin
                    pos_next = CNT_W'(mid_reg);
                    case (op_reg)
                        OP_INSERT: begin
                            status_next = ST_DUPLICATE;
                            state_next  = S_RESULT;
                        end
                        OP_DELETE: begin
                            cursor_next = CNT_W'(mid_reg) + CNT_W'(1);
                            state_next  = S_SHIFT_DN;
                        end
                        default: begin
                            fval_next  = rd_value;
                            state_next = S_RESULT;
                        end
                    endcase
                end else begin
                    if (rd_key > key_reg) begin
                        hi_next = CNT_W'(mid_reg);
                    end else begin
                        lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end
                    state_next = S_PROBE;
                end
            end

            // move records up one slot, highest first, one per cycle
            S_SHIFT_UP: begin
                ram_we    = wb_valid_reg;
                ram_raddr = IDX_W'(cursor_reg - CNT_W'(1));
                if (cursor_reg > pos_reg) begin
                    wb_valid_next = 1'b1;
                    wb_addr_next  = cursor_reg[IDX_W-1:0];
                    cursor_next   = cursor_reg - CNT_W'(1);
                end else if (!wb_valid_reg) begin
                    state_next = S_STORE;
                end
            end

            // write the new record into the gap
            S_STORE: begin
                ram_we      = 1'b1;
                ram_waddr   = pos_reg[IDX_W-1:0];
                ram_wdata   = {key_reg, value_reg};
                count_next  = count_reg + CNT_W'(1);
                probes_next = probes_reg + PRB_W'(1);
                state_next  = S_RESULT;
            end

            // move records down one slot, lowest first, one per cycle
            S_SHIFT_DN: begin
                ram_we    = wb_valid_reg;
                ram_raddr = cursor_reg[IDX_W-1:0];
                if (cursor_reg < count_reg) begin
                    wb_valid_next = 1'b1;
                    wb_addr_next  = IDX_W'(cursor_reg - CNT_W'(1));
                    cursor_next   = cursor_reg + CNT_W'(1);
                end else if (!wb_valid_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESULT;
                end
            end

            // load the output register once it is free
            S_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next            = 1'b1;
                    m_status_next           = status_reg;
                    m_data_next.pad         = '0;
                    m_data_next.position    = POS_W'(pos_reg);
                    m_data_next.found_value = fval_reg;
                    m_data_next.entry_count = POS_W'(count_reg);
                    m_data_next.probes      = (probes_reg > PRB_W'(7)) ?
                                              PROBE_W'(7) : PROBE_W'(probes_reg);
                    state_next              = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wb_valid_reg <= 1'b0;
            count_reg    <= '0;
            limit_reg    <= LIMIT_W'(64);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wb_valid_reg <= wb_valid_next;
            count_reg    <= count_next;
            limit_reg    <= limit_next;
            m_valid_reg  <= m_valid_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        probes_reg   <= probes_next;
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        fval_reg     <= fval_next;
        cursor_reg   <= cursor_next;
        wb_addr_reg  <= wb_addr_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ===== src/skt_checker.sv =====
// ---------------------------------------------------------------------------
// skt_checker
// Port-level checks for the sorted key table, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module skt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [skt_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [skt_pkg::STAT_W-1:0]     m_tuser
);

    import skt_pkg::*;

    skt_out_data_t out_data;

    assign out_data = skt_out_data_t'(m_tdata);

    // a stalled result beat stays put
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat dropped or changed while stalled")

    // one item at a time: busy right after an input beat
    `ASSERT_CLK(a_busy_after_beat, s_tvalid && s_tready |=> !s_tready, "input accepted while previous item still in work")

    // record count never exceeds capacity
    `ASSERT_CLK(a_count_range, m_tvalid |-> 32'(out_data.entry_count) <= 32'(CAPACITY), "entry count above capacity")

    // a full table makes no search
    `ASSERT_CLK(a_full_no_search, m_tvalid && m_tuser == ST_FULL |-> out_data.probes == '0 && out_data.position == '0, "full status with nonzero probes or position")

    // only a successful find returns a value
    `ASSERT_CLK(a_fval_zero, m_tvalid && m_tuser != ST_OK |-> out_data.found_value == '0, "found value set on a failed operation")

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);
